### rtl/refcounted_page_frame_allocator_defines.svh
// Assertion macros for the page frame allocator.
// Taken in by the top level; depends on nothing else.
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define RPFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpfa: same-cycle check failed");

// Next-cycle implication under an active-low reset.
`define RPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpfa: next-cycle check failed");

`endif

### rtl/rpfa_pkg.sv
// Shared types and constants of the page frame allocator.
// Used by the interfaces and the top level; depends on nothing.
`default_nettype none

package rpfa_pkg;

    // Fixed field widths of the words on the channels.
    localparam int OPCODE_W = 3;
    localparam int PAGE_W   = 16;
    localparam int VA_W     = 48;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 17;

    localparam logic [COUNT_W-1:0] CNT_MAX = 17'h1FFFF;

    // Configuration register indexes.
    localparam logic CFG_TOTAL_PAGES     = 1'b0;
    localparam logic CFG_KERNEL_END_PAGE = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC       = 3'd0,
        OP_FREE        = 3'd1,
        OP_ADD_REF     = 3'd2,
        OP_COW_CHECK   = 3'd3,
        OP_MARK_USER   = 3'd4,
        OP_MARK_KERNEL = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_FREE     = 3'd1,
        ST_INVALID     = 3'd2,
        ST_SHARED      = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_ALLOC_WR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/rpfa_in_if.sv
// Request channel of the page frame allocator: valid/ready plus one word.
// Depends on rpfa_pkg for the field widths.
`default_nettype none

interface rpfa_in_if;
    logic                           valid;
    logic                           ready;
    logic [rpfa_pkg::OPCODE_W-1:0]  opcode;
    logic [rpfa_pkg::PAGE_W-1:0]    page_number;
    logic [rpfa_pkg::VA_W-1:0]      virtual_addr;

    modport source (output valid, opcode, page_number, virtual_addr, input ready);
    modport sink   (input valid, opcode, page_number, virtual_addr, output ready);
endinterface

`default_nettype wire

### rtl/rpfa_out_if.sv
// Result channel of the page frame allocator: valid/ready plus one word.
// Depends on rpfa_pkg for the field widths.
`default_nettype none

interface rpfa_out_if;
    logic                           valid;
    logic                           ready;
    logic [rpfa_pkg::STATUS_W-1:0]  status;
    logic [rpfa_pkg::PAGE_W-1:0]    result_page;
    logic [rpfa_pkg::PAGE_W-1:0]    ref_count_after;
    logic [rpfa_pkg::COUNT_W-1:0]   free_count;
    logic [rpfa_pkg::COUNT_W-1:0]   in_use_count;

    modport source (output valid, status, result_page, ref_count_after, free_count,
                    in_use_count, input ready);
    modport sink   (input valid, status, result_page, ref_count_after, free_count,
                    in_use_count, output ready);
endinterface

`default_nettype wire

### rtl/rpfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Stand-alone; used for the frame table and the availability bitmap.
`default_nettype none

module rpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/refcounted_page_frame_allocator.sv
// Reference-counted page frame allocator. After reset the block sweeps both
// memories clear, one frame table entry per cycle, and accepts no word until
// then; configuration writes are taken at any time.
// Free, add reference, copy-on-write check and the mark operations pass through
// the accept in S_IDLE, S_READ for the frame table read data and its write
// back, and S_DONE, which loads the output register.
// Allocate scans the availability bitmap one WW-bit word per cycle (64 bits
// unless MAX_PAGES is smaller), starting at the lowest word that may hold an
// available frame; after the accept it spends one S_SCAN step per bitmap word
// scanned (1 to MAX_PAGES/WW words), then S_ALLOC_WR when it finds a frame, and S_DONE.
// One word is in flight at a time; a finished result waits in the output
// register, and a result that is not taken holds the next word in S_DONE.
`default_nettype none
`include "refcounted_page_frame_allocator_defines.svh"

module refcounted_page_frame_allocator #(
    parameter int MAX_PAGES   = 65536,
    parameter int REF_WIDTH   = 16,
    parameter int VADDR_WIDTH = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rpfa_in_if.sink                            i_in,
    rpfa_out_if.source                         o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [rpfa_pkg::COUNT_W-1:0]  i_cfg_wdata
);

    localparam int PW  = $clog2(MAX_PAGES);
    localparam int CW  = (PW + 1 > rpfa_pkg::COUNT_W) ? PW + 1 : rpfa_pkg::COUNT_W;
    localparam int WW  = (MAX_PAGES < 64) ? MAX_PAGES : 64;
    localparam int BW  = $clog2(WW);
    localparam int NW  = MAX_PAGES / WW;
    localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
    localparam int RW  = REF_WIDTH;
    localparam int VW  = VADDR_WIDTH;
    localparam int EW  = 1 + VW + RW;

    localparam logic [RW-1:0]  REF_MAX   = {RW{1'b1}};
    localparam logic [RW-1:0]  REF_ONE   = RW'(1);
    localparam logic [CW-1:0]  MAX_EXT   = CW'(MAX_PAGES);
    localparam logic [WIW-1:0] LAST_WORD = WIW'(NW - 1);
    localparam logic [PW-1:0]  LAST_PAGE = PW'(MAX_PAGES - 1);

    // Control registers.
    rpfa_pkg::t_state r_state, n_state;
    logic [PW-1:0]                   r_clr;
    logic [WIW-1:0]                  r_hint, n_hint;
    logic [WIW-1:0]                  r_chk;
    logic [rpfa_pkg::COUNT_W-1:0]    r_avail, n_avail;
    logic [rpfa_pkg::COUNT_W-1:0]    r_alloc, n_alloc;
    logic [rpfa_pkg::COUNT_W-1:0]    r_total;
    logic [rpfa_pkg::PAGE_W-1:0]     r_kend;
    logic                            r_out_valid;

    // Latched request and staged result.
    logic [rpfa_pkg::OPCODE_W-1:0]   r_op;
    logic [rpfa_pkg::PAGE_W-1:0]     r_pg;
    logic [VW-1:0]                   r_va;
    logic [PW-1:0]                   r_fpage, n_fpage;
    logic [WW-1:0]                   r_word, n_word;
    rpfa_pkg::t_status               r_res_st, n_res_st;
    logic [rpfa_pkg::PAGE_W-1:0]     r_res_pg, n_res_pg;
    logic [RW-1:0]                   r_res_ref, n_res_ref;
    logic [rpfa_pkg::STATUS_W-1:0]   r_out_st;
    logic [rpfa_pkg::PAGE_W-1:0]     r_out_pg;
    logic [rpfa_pkg::PAGE_W-1:0]     r_out_ref;
    logic [rpfa_pkg::COUNT_W-1:0]    r_out_free;
    logic [rpfa_pkg::COUNT_W-1:0]    r_out_used;

    // Memory ports.
    logic            ent_we;
    logic [PW-1:0]   ent_waddr, ent_raddr;
    logic [EW-1:0]   ent_wdata, ent_rdata;
    logic            bm_we;
    logic [WIW-1:0]  bm_waddr, bm_raddr;
    logic [WW-1:0]   bm_wdata, bm_rdata;

    // Frame table entry: user bit, virtual address, reference count.
    rpfa_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES), .AW(PW)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // Availability bitmap, WW frames per word.
    rpfa_ram #(.WIDTH(WW), .DEPTH(NW), .AW(WIW)) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    // Decoded request and entry fields.
    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  pg_ext;
    logic [PW-1:0]  pg_idx;
    logic [WIW-1:0] pg_word;
    logic [BW-1:0]  pg_bit;
    logic [RW-1:0]  e_refs;
    logic [VW-1:0]  e_va;
    logic           e_user;
    logic           pg_avail;
    logic           req_invalid;
    logic           in_fire;

    assign n_eff    = (CW'(r_total) < MAX_EXT) ? CW'(r_total) : MAX_EXT;
    assign pg_ext   = CW'(r_pg);
    assign pg_idx   = PW'(r_pg);
    assign pg_word  = WIW'(pg_idx >> BW);
    assign pg_bit   = BW'(pg_idx);
    assign e_refs   = ent_rdata[RW-1:0];
    assign e_va     = ent_rdata[RW+VW-1:RW];
    assign e_user   = ent_rdata[EW-1];
    assign pg_avail = bm_rdata[pg_bit];
    assign req_invalid = (r_op > 3'(rpfa_pkg::OP_MARK_KERNEL)) || (pg_ext >= n_eff);
    assign in_fire  = i_in.valid && i_in.ready;

    // Scan of the bitmap word that arrived this cycle.
    logic [CW-1:0]  scan_base;
    logic [BW-1:0]  scan_idx;
    logic           scan_any;
    logic [CW-1:0]  scan_page;
    logic           scan_found;
    logic           scan_stop;

    always_comb begin
        scan_idx = '0;
        scan_any = 1'b0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (bm_rdata[i]) begin
                scan_idx = BW'(i);
                scan_any = 1'b1;
            end
        end
    end

    assign scan_base  = CW'(r_chk) << BW;
    assign scan_page  = scan_base + CW'(scan_idx);
    assign scan_found = (scan_base < n_eff) && scan_any && (scan_page < n_eff);
    assign scan_stop  = scan_found || (scan_base >= n_eff) || scan_any || (r_chk == LAST_WORD);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpfa_pkg::S_CLEAR: begin
                if (r_clr == LAST_PAGE) begin
                    n_state = rpfa_pkg::S_IDLE;
                end
            end
            rpfa_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in.opcode == 3'(rpfa_pkg::OP_ALLOC)) ? rpfa_pkg::S_SCAN
                                                                     : rpfa_pkg::S_READ;
                end
            end
            rpfa_pkg::S_READ: begin
                n_state = rpfa_pkg::S_DONE;
            end
            rpfa_pkg::S_SCAN: begin
                if (scan_found) begin
                    n_state = rpfa_pkg::S_ALLOC_WR;
                end else if (scan_stop) begin
                    n_state = rpfa_pkg::S_DONE;
                end
            end
            rpfa_pkg::S_ALLOC_WR: begin
                n_state = rpfa_pkg::S_DONE;
            end
            rpfa_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = rpfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpfa_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath: memory accesses, counters and the staged result.
    always_comb begin
        n_hint    = r_hint;
        n_avail   = r_avail;
        n_alloc   = r_alloc;
        n_fpage   = r_fpage;
        n_word    = r_word;
        n_res_st  = r_res_st;
        n_res_pg  = r_res_pg;
        n_res_ref = r_res_ref;
        ent_we    = 1'b0;
        ent_waddr = pg_idx;
        ent_wdata = ent_rdata;
        ent_raddr = PW'(i_in.page_number);
        bm_we     = 1'b0;
        bm_waddr  = pg_word;
        bm_wdata  = bm_rdata;
        bm_raddr  = WIW'(PW'(i_in.page_number) >> BW);
        case (r_state)
            rpfa_pkg::S_CLEAR: begin
                // Sweep both memories to zero.
                ent_we    = 1'b1;
                ent_waddr = r_clr;
                ent_wdata = '0;
                bm_we     = 1'b1;
                bm_waddr  = WIW'(r_clr >> BW);
                bm_wdata  = '0;
            end
            rpfa_pkg::S_IDLE: begin
                // Allocate starts its scan at the hint word.
                if (i_in.opcode == 3'(rpfa_pkg::OP_ALLOC)) begin
                    bm_raddr = r_hint;
                end
            end
            rpfa_pkg::S_READ: begin
                n_res_pg  = r_pg;
                n_res_ref = e_refs;
                n_res_st  = rpfa_pkg::ST_OK;
                if (req_invalid) begin
                    n_res_st  = rpfa_pkg::ST_INVALID;
                    n_res_ref = '0;
                end else begin
                    case (r_op)
                        rpfa_pkg::OP_FREE: begin
                            if (r_pg < r_kend) begin
                                n_res_st  = rpfa_pkg::ST_INVALID;
                                n_res_ref = '0;
                            end else if (pg_avail) begin
                                n_res_st = rpfa_pkg::ST_DOUBLE_FREE;
                            end else if (e_refs > REF_ONE) begin
                                // Shared frame: drop one reference.
                                n_res_st  = rpfa_pkg::ST_SHARED;
                                n_res_ref = e_refs - REF_ONE;
                                ent_we    = 1'b1;
                                ent_wdata = {e_user, e_va, e_refs - REF_ONE};
                            end else begin
                                // Last reference: release and clear the frame.
                                n_res_ref = '0;
                                ent_we    = 1'b1;
                                ent_wdata = '0;
                                bm_we     = 1'b1;
                                bm_wdata  = bm_rdata | (WW'(1) << pg_bit);
                                if (r_alloc != '0) begin
                                    n_alloc = r_alloc - 1'b1;
                                end
                                if (r_avail != rpfa_pkg::CNT_MAX) begin
                                    n_avail = r_avail + 1'b1;
                                end
                                if (pg_word < r_hint) begin
                                    n_hint = pg_word;
                                end
                            end
                        end
                        rpfa_pkg::OP_ADD_REF: begin
                            if (e_refs != REF_MAX) begin
                                n_res_ref = e_refs + REF_ONE;
                            end
                            ent_we    = 1'b1;
                            ent_wdata = {e_user, e_va, n_res_ref};
                        end
                        rpfa_pkg::OP_COW_CHECK: begin
                            if (e_refs > REF_ONE) begin
                                n_res_st  = rpfa_pkg::ST_SHARED;
                                n_res_ref = e_refs - REF_ONE;
                                ent_we    = 1'b1;
                                ent_wdata = {e_user, e_va, e_refs - REF_ONE};
                            end
                        end
                        rpfa_pkg::OP_MARK_USER: begin
                            ent_we    = 1'b1;
                            ent_wdata = {1'b1, r_va, e_refs};
                        end
                        default: begin
                            // Mark kernel.
                            ent_we    = 1'b1;
                            ent_wdata = {1'b0, {VW{1'b0}}, e_refs};
                        end
                    endcase
                end
            end
            rpfa_pkg::S_SCAN: begin
                // Fetch the next word while checking this one.
                bm_raddr  = r_chk + 1'b1;
                ent_raddr = PW'(scan_page);
                n_fpage   = PW'(scan_page);
                n_word    = bm_rdata & ~(WW'(1) << scan_idx);
                n_hint    = r_chk;
                if (!scan_found) begin
                    n_res_st  = rpfa_pkg::ST_NO_FREE;
                    n_res_pg  = '0;
                    n_res_ref = '0;
                end
            end
            rpfa_pkg::S_ALLOC_WR: begin
                // Take the frame: clear its bit, set one reference.
                ent_we    = 1'b1;
                ent_waddr = r_fpage;
                ent_wdata = {e_user, e_va, REF_ONE};
                bm_we     = 1'b1;
                bm_waddr  = r_hint;
                bm_wdata  = r_word;
                n_res_st  = rpfa_pkg::ST_OK;
                n_res_pg  = rpfa_pkg::PAGE_W'(r_fpage);
                n_res_ref = REF_ONE;
                if (r_alloc != rpfa_pkg::CNT_MAX) begin
                    n_alloc = r_alloc + 1'b1;
                end
                if (r_avail != '0) begin
                    n_avail = r_avail - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpfa_pkg::S_CLEAR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_chk       <= '0;
            r_avail     <= '0;
            r_alloc     <= '0;
            r_total     <= rpfa_pkg::COUNT_W'(65536);
            r_kend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            r_avail <= n_avail;
            r_alloc <= n_alloc;
            if (r_state == rpfa_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == rpfa_pkg::S_IDLE) begin
                r_chk <= r_hint;
            end else if (r_state == rpfa_pkg::S_SCAN) begin
                r_chk <= r_chk + 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == rpfa_pkg::CFG_TOTAL_PAGES) begin
                    r_total <= i_cfg_wdata;
                end else begin
                    r_kend <= i_cfg_wdata[rpfa_pkg::PAGE_W-1:0];
                end
            end
            if (r_state == rpfa_pkg::S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= i_in.opcode;
            r_pg <= i_in.page_number;
            r_va <= VW'(i_in.virtual_addr);
        end
        r_fpage   <= n_fpage;
        r_word    <= n_word;
        r_res_st  <= n_res_st;
        r_res_pg  <= n_res_pg;
        r_res_ref <= n_res_ref;
        if (r_state == rpfa_pkg::S_DONE && (!r_out_valid || o_out.ready)) begin
            r_out_st   <= r_res_st;
            r_out_pg   <= r_res_pg;
            r_out_ref  <= rpfa_pkg::PAGE_W'(r_res_ref);
            r_out_free <= r_avail;
            r_out_used <= r_alloc;
        end
    end

    // Channel outputs.
    assign i_in.ready            = (r_state == rpfa_pkg::S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_st;
    assign o_out.result_page     = r_out_pg;
    assign o_out.ref_count_after = r_out_ref;
    assign o_out.free_count      = r_out_free;
    assign o_out.in_use_count    = r_out_used;

    // Checks on the sequencing.
    `RPFA_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == rpfa_pkg::S_CLEAR, !i_in.ready)
    `RPFA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_fire, r_state != rpfa_pkg::S_IDLE)
    `RPFA_ASSERT_NOW(a_scan_steps_by_one, i_clk, i_rst_n, r_state == rpfa_pkg::S_SCAN && $past(r_state) == rpfa_pkg::S_SCAN, r_chk == WIW'($past(r_chk) + 1'b1))
    `RPFA_ASSERT_NOW(a_done_blocks_input, i_clk, i_rst_n, r_state == rpfa_pkg::S_DONE, !i_in.ready)

endmodule

`default_nettype wire
